@@ rtl/pbag_pkg.sv @@
// Shared types, constants and helpers of the palette block-average glyph block.
package pbag_pkg;

  // Storage sizes.
  localparam int PALETTE_ENTRIES   = 256;
  localparam int PAL_AW            = 8;
  localparam int MAX_BLOCK_COLUMNS = 128;
  localparam int COL_W             = 7;
  localparam int MAX_IMAGE_WIDTH   = 4096;

  // Field and counter widths.
  localparam int IW_W    = 13;
  localparam int BW_W    = 7;
  localparam int BH_W    = 8;
  localparam int CP_W    = 12;
  localparam int CIB_W   = 6;
  localparam int RIB_W   = 7;
  localparam int NCOLS_W = 8;
  localparam int AREA_W  = 14;
  localparam int SUM_W   = 21;
  localparam int GREY_W  = 8;
  localparam int CFG_W   = 13;
  localparam int CFG_AW  = 2;
  localparam int GLYPH_W = 7;
  localparam int LEVEL_W = 3;

  // Register limits and reset values.
  localparam int BW_MAX       = 64;
  localparam int BH_MAX       = 128;
  localparam int IW_RESET     = 640;
  localparam int BW_RESET     = 9;
  localparam int BH_RESET     = 18;
  localparam int NCOLS_RESET  = (IW_RESET / BW_RESET > MAX_BLOCK_COLUMNS) ?
                                MAX_BLOCK_COLUMNS : IW_RESET / BW_RESET;
  localparam int NCOLS_BW_RESET = NCOLS_RESET * BW_RESET;
  localparam int AREA_RESET     = BW_RESET * BH_RESET;

  // Queue between the front and back parts.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = 2;
  localparam int FIFO_CW    = 3;

  // Glyph characters, darkest first.
  localparam logic [GLYPH_W-1:0] CH_SPACE = 7'h20;
  localparam logic [GLYPH_W-1:0] CH_DOT   = 7'h2E;
  localparam logic [GLYPH_W-1:0] CH_DASH  = 7'h2D;
  localparam logic [GLYPH_W-1:0] CH_PLUS  = 7'h2B;
  localparam logic [GLYPH_W-1:0] CH_STAR  = 7'h2A;
  localparam logic [GLYPH_W-1:0] CH_AMP   = 7'h26;
  localparam logic [GLYPH_W-1:0] CH_PCT   = 7'h25;
  localparam logic [GLYPH_W-1:0] CH_HASH  = 7'h23;

  // Configuration register indexes.
  typedef enum logic [CFG_AW-1:0] {
    REG_IMAGE_WIDTH  = 2'd0,
    REG_BLOCK_WIDTH  = 2'd1,
    REG_BLOCK_HEIGHT = 2'd2,
    REG_INVERT_MODE  = 2'd3
  } cfg_idx_e;

  // Setup sequencer states.
  typedef enum logic [2:0] {
    SET_IDLE,
    SET_LOAD,
    SET_DIV,
    SET_CAP,
    SET_MUL
  } set_state_e;

  // Back part states.
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_DIV,
    BK_WRITE
  } bk_state_e;

  // Settled configuration as seen by the datapath.
  typedef struct packed {
    logic                busy;
    logic [IW_W-1:0]     iw;
    logic [BW_W-1:0]     bw;
    logic [BH_W-1:0]     bh;
    logic [NCOLS_W-1:0]  ncols;
    logic [AREA_W-1:0]   ncols_bw;
    logic [AREA_W-1:0]   area;
    logic                invert;
  } cfg_t;

  // One finished block sum waiting for division.
  typedef struct packed {
    logic [SUM_W-1:0] sum;
    logic             eor;
  } blk_entry_t;

  // Map a brightness bucket to its glyph.
  function automatic logic [GLYPH_W-1:0] glyph_of(input logic [LEVEL_W-1:0] lvl);
    logic [GLYPH_W-1:0] g;
    case (lvl)
      3'd0:    g = CH_SPACE;
      3'd1:    g = CH_DOT;
      3'd2:    g = CH_DASH;
      3'd3:    g = CH_PLUS;
      3'd4:    g = CH_STAR;
      3'd5:    g = CH_AMP;
      3'd6:    g = CH_PCT;
      default: g = CH_HASH;
    endcase
    return g;
  endfunction

endpackage

@@ rtl/pbag_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
module pbag_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // A read at the address being written returns the old contents.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

@@ rtl/pbag_setup.sv @@
// Configuration registers and the derived block counts, worked out after each write.
module pbag_setup
  import pbag_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              cfg_we_i,
  input  logic [CFG_AW-1:0] cfg_index_i,
  input  logic [CFG_W-1:0]  cfg_data_i,
  output cfg_t              cfg_o
);

  logic [IW_W-1:0]    iw_q;
  logic [BW_W-1:0]    bw_q;
  logic [BH_W-1:0]    bh_q;
  logic               inv_q;
  logic [IW_W-1:0]    iw_c;
  logic [BW_W-1:0]    bw_c;
  logic [BH_W-1:0]    bh_c;
  set_state_e         state_q, state_d;
  logic [IW_W-1:0]    dvd_q;
  logic [IW_W-1:0]    quo_q;
  logic [BW_W-1:0]    rem_q;
  logic [3:0]         cnt_q;
  logic [BW_W:0]      trial;
  logic               ge;
  logic [NCOLS_W-1:0] ncols_q;
  logic [AREA_W-1:0]  ncols_bw_q;
  logic [AREA_W-1:0]  area_q;
  logic               busy;

  // Raw register writes.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      iw_q  <= IW_W'(IW_RESET);
      bw_q  <= BW_W'(BW_RESET);
      bh_q  <= BH_W'(BH_RESET);
      inv_q <= 1'b0;
    end else if (cfg_we_i) begin
      case (cfg_idx_e'(cfg_index_i))
        REG_IMAGE_WIDTH:  iw_q  <= cfg_data_i[IW_W-1:0];
        REG_BLOCK_WIDTH:  bw_q  <= cfg_data_i[BW_W-1:0];
        REG_BLOCK_HEIGHT: bh_q  <= cfg_data_i[BH_W-1:0];
        REG_INVERT_MODE:  inv_q <= cfg_data_i[0];
        default: ;
      endcase
    end
  end

  // Saturate the sizes to their legal ranges; zero counts as one.
  always_comb begin
    if (iw_q == '0) begin
      iw_c = IW_W'(1);
    end else if (iw_q > IW_W'(MAX_IMAGE_WIDTH)) begin
      iw_c = IW_W'(MAX_IMAGE_WIDTH);
    end else begin
      iw_c = iw_q;
    end
    if (bw_q == '0) begin
      bw_c = BW_W'(1);
    end else if (bw_q > BW_W'(BW_MAX)) begin
      bw_c = BW_W'(BW_MAX);
    end else begin
      bw_c = bw_q;
    end
    if (bh_q == '0) begin
      bh_c = BH_W'(1);
    end else if (bh_q > BH_W'(BH_MAX)) begin
      bh_c = BH_W'(BH_MAX);
    end else begin
      bh_c = bh_q;
    end
  end

  // One restoring division step: image width over block width.
  assign trial = {rem_q, dvd_q[IW_W-1]};
  assign ge    = trial >= {1'b0, bw_c};

  // Next state of the setup sequencer; any write restarts it.
  always_comb begin
    state_d = state_q;
    if (cfg_we_i) begin
      state_d = SET_LOAD;
    end else begin
      case (state_q)
        SET_IDLE: state_d = SET_IDLE;
        SET_LOAD: state_d = SET_DIV;
        SET_DIV:  state_d = (cnt_q == 4'd0) ? SET_CAP : SET_DIV;
        SET_CAP:  state_d = SET_MUL;
        SET_MUL:  state_d = SET_IDLE;
        default:  state_d = SET_IDLE;
      endcase
    end
  end

  // Outputs of the sequencer.
  always_comb begin
    busy = cfg_we_i || (state_q != SET_IDLE);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= SET_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Divider and derived-count registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dvd_q      <= '0;
      quo_q      <= '0;
      rem_q      <= '0;
      cnt_q      <= '0;
      ncols_q    <= NCOLS_W'(NCOLS_RESET);
      ncols_bw_q <= AREA_W'(NCOLS_BW_RESET);
      area_q     <= AREA_W'(AREA_RESET);
    end else begin
      case (state_q)
        SET_LOAD: begin
          dvd_q <= iw_c;
          quo_q <= '0;
          rem_q <= '0;
          cnt_q <= 4'(IW_W - 1);
        end
        SET_DIV: begin
          dvd_q <= {dvd_q[IW_W-2:0], 1'b0};
          quo_q <= {quo_q[IW_W-2:0], ge};
          rem_q <= ge ? BW_W'(trial - {1'b0, bw_c}) : trial[BW_W-1:0];
          cnt_q <= cnt_q - 4'd1;
        end
        SET_CAP: begin
          ncols_q <= (quo_q > IW_W'(MAX_BLOCK_COLUMNS)) ? NCOLS_W'(MAX_BLOCK_COLUMNS)
                                                          : quo_q[NCOLS_W-1:0];
        end
        SET_MUL: begin
          ncols_bw_q <= AREA_W'(ncols_q) * AREA_W'(bw_c);
          area_q     <= AREA_W'(bw_c) * AREA_W'(bh_c);
        end
        default: ;
      endcase
    end
  end

  assign cfg_o.busy     = busy;
  assign cfg_o.iw       = iw_c;
  assign cfg_o.bw       = bw_c;
  assign cfg_o.bh       = bh_c;
  assign cfg_o.ncols    = ncols_q;
  assign cfg_o.ncols_bw = ncols_bw_q;
  assign cfg_o.area     = area_q;
  assign cfg_o.invert   = inv_q;

endmodule

@@ rtl/pbag_front.sv @@
// Front part: palette loads, raster position tracking and block sum accumulation.
module pbag_front
  import pbag_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push,
  output logic               full,
  input  logic               action_i,
  input  logic [7:0]         color_index_i,
  input  logic [7:0]         blue_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         red_i,
  input  logic               frame_start_i,
  input  cfg_t               cfg_i,
  input  logic [FIFO_CW-1:0] fifo_count_i,
  output logic               fifo_push_o,
  output blk_entry_t         fifo_data_o
);

  logic               accept;
  logic               pix;
  logic [15:0]        wsum;
  logic [GREY_W-1:0]  grey_rd;
  logic [SUM_W-1:0]   sum_rd;

  logic [CP_W-1:0]    cp_q, cp_c, cp_d;
  logic [CIB_W-1:0]   cib_q, cib_c, cib_d;
  logic [COL_W-1:0]   bc_q, bc_c, bc_d;
  logic [RIB_W-1:0]   rib_q, rib_c, rib_d;
  logic [NCOLS_W-1:0] bc_inc;

  logic               in_full, first, last, eor;

  logic               s1_valid_q;
  logic               s1_full_q, s1_first_q, s1_last_q, s1_eor_q;
  logic [COL_W-1:0]   s1_col_q;
  logic [SUM_W-1:0]   old_sum, new_sum;
  logic               sum_we;

  logic               fwd_valid_q;
  logic [COL_W-1:0]   fwd_col_q;
  logic [SUM_W-1:0]   fwd_sum_q;

  // Hold off input during setup and while the queue could overflow.
  assign full   = cfg_i.busy ||
                  (FIFO_CW'(fifo_count_i + FIFO_CW'(s1_valid_q)) >= FIFO_CW'(FIFO_DEPTH));
  assign accept = push && !full;
  assign pix    = accept && action_i;

  // Grey level of a palette entry in 8.8 fixed point.
  assign wsum = 16'(blue_i) * 16'd28 + 16'(green_i) * 16'd151 + 16'(red_i) * 16'd77;

  pbag_ram #(
    .WIDTH (GREY_W),
    .DEPTH (PALETTE_ENTRIES)
  ) u_palette (
    .clk_i   (clk_i),
    .we_i    (accept && !action_i),
    .waddr_i (color_index_i),
    .wdata_i (wsum[15:8]),
    .raddr_i (color_index_i),
    .rdata_o (grey_rd)
  );

  // Position counters as seen by this pixel, after a frame start clear.
  always_comb begin
    cp_c  = frame_start_i ? '0 : cp_q;
    cib_c = frame_start_i ? '0 : cib_q;
    bc_c  = frame_start_i ? '0 : bc_q;
    rib_c = frame_start_i ? '0 : rib_q;
  end

  // Classify the pixel against the full-block area of the row.
  always_comb begin
    in_full = (cfg_i.ncols != '0) && (AREA_W'(cp_c) < cfg_i.ncols_bw) &&
              (NCOLS_W'(bc_c) < cfg_i.ncols);
    first   = (rib_c == '0) && (cib_c == '0);
    last    = (BW_W'(cib_c) >= BW_W'(cfg_i.bw - BW_W'(1))) &&
              (BH_W'(rib_c) >= BH_W'(cfg_i.bh - BH_W'(1)));
    eor     = NCOLS_W'(bc_c) == NCOLS_W'(cfg_i.ncols - NCOLS_W'(1));
  end

  // Advance the raster position.
  always_comb begin
    cp_d   = cp_c;
    cib_d  = cib_c;
    bc_d   = bc_c;
    rib_d  = rib_c;
    bc_inc = NCOLS_W'(bc_c) + NCOLS_W'(1);
    if (IW_W'(cp_c) >= IW_W'(cfg_i.iw - IW_W'(1))) begin
      cp_d  = '0;
      cib_d = '0;
      bc_d  = '0;
      if (BH_W'(rib_c) >= BH_W'(cfg_i.bh - BH_W'(1))) begin
        rib_d = '0;
      end else begin
        rib_d = rib_c + RIB_W'(1);
      end
    end else begin
      cp_d = cp_c + CP_W'(1);
      if (BW_W'(cib_c) >= BW_W'(cfg_i.bw - BW_W'(1))) begin
        cib_d = '0;
        if (bc_inc < cfg_i.ncols) begin
          bc_d = bc_inc[COL_W-1:0];
        end else if (cfg_i.ncols > NCOLS_W'(MAX_BLOCK_COLUMNS - 1)) begin
          bc_d = COL_W'(MAX_BLOCK_COLUMNS - 1);
        end else begin
          bc_d = cfg_i.ncols[COL_W-1:0];
        end
      end else begin
        cib_d = cib_c + CIB_W'(1);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cp_q  <= '0;
      cib_q <= '0;
      bc_q  <= '0;
      rib_q <= '0;
    end else if (pix) begin
      cp_q  <= cp_d;
      cib_q <= cib_d;
      bc_q  <= bc_d;
      rib_q <= rib_d;
    end
  end

  // Pixel stage that waits for the palette and sum reads.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
    end else begin
      s1_valid_q <= pix;
    end
  end

  always_ff @(posedge clk_i) begin
    if (pix) begin
      s1_full_q  <= in_full;
      s1_first_q <= first;
      s1_last_q  <= last;
      s1_eor_q   <= eor;
      s1_col_q   <= bc_c;
    end
  end

  pbag_ram #(
    .WIDTH (SUM_W),
    .DEPTH (MAX_BLOCK_COLUMNS)
  ) u_sums (
    .clk_i   (clk_i),
    .we_i    (sum_we),
    .waddr_i (s1_col_q),
    .wdata_i (new_sum),
    .raddr_i (bc_c),
    .rdata_o (sum_rd)
  );

  // Accumulate; a write to the same column in the previous cycle is forwarded.
  always_comb begin
    old_sum = (fwd_valid_q && (fwd_col_q == s1_col_q)) ? fwd_sum_q : sum_rd;
    new_sum = s1_first_q ? SUM_W'(grey_rd) : old_sum + SUM_W'(grey_rd);
    sum_we  = s1_valid_q && s1_full_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fwd_valid_q <= 1'b0;
    end else begin
      fwd_valid_q <= sum_we;
    end
  end

  always_ff @(posedge clk_i) begin
    if (sum_we) begin
      fwd_col_q <= s1_col_q;
      fwd_sum_q <= new_sum;
    end
  end

  // A completed block goes to the queue.
  assign fifo_push_o     = sum_we && s1_last_q;
  assign fifo_data_o.sum = new_sum;
  assign fifo_data_o.eor = s1_eor_q;

endmodule

@@ rtl/pbag_fifo.sv @@
// Short queue of completed block sums between the front and back parts.
module pbag_fifo
  import pbag_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               push_i,
  input  blk_entry_t         data_i,
  input  logic               pop_i,
  output blk_entry_t         data_o,
  output logic               empty_o,
  output logic [FIFO_CW-1:0] count_o
);

  blk_entry_t         slot_q [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_ptr_q, rd_ptr_q;
  logic [FIFO_CW-1:0] count_q;
  logic               do_push, do_pop;

  assign do_push = push_i && (count_q != FIFO_CW'(FIFO_DEPTH));
  assign do_pop  = pop_i && (count_q != '0);

  // Pointers and fill count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= wr_ptr_q + FIFO_AW'(1);
      end
      if (do_pop) begin
        rd_ptr_q <= rd_ptr_q + FIFO_AW'(1);
      end
      count_q <= count_q + FIFO_CW'(do_push) - FIFO_CW'(do_pop);
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      slot_q[wr_ptr_q] <= data_i;
    end
  end

  assign data_o  = slot_q[rd_ptr_q];
  assign empty_o = (count_q == '0);
  assign count_o = count_q;

endmodule

@@ rtl/pbag_back.sv @@
// Back part: divides each block sum by the block area and forms the glyph item.
module pbag_back
  import pbag_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  input  blk_entry_t          fifo_data_i,
  input  logic                fifo_empty_i,
  output logic                fifo_pop_o,
  input  cfg_t                cfg_i,
  input  logic                pop,
  output logic                empty,
  output logic [GLYPH_W-1:0]  glyph_o,
  output logic [LEVEL_W-1:0]  level_o,
  output logic                end_of_row_o
);

  bk_state_e            state_q, state_d;
  logic [SUM_W-1:0]     rem_q;
  logic [SUM_W-1:0]     dsh_q;
  logic [7:0]           quo_q;
  logic [2:0]           cnt_q;
  logic                 eor_q;
  logic                 sat;
  logic                 step_ge;
  logic                 out_load;
  logic                 out_valid_q;
  logic [7:0]           value;
  logic [GLYPH_W-1:0]   glyph_q;
  logic [LEVEL_W-1:0]   level_q;
  logic                 out_eor_q;

  // Averages of 256 or more saturate without dividing.
  assign sat     = {1'b0, fifo_data_i.sum} >= {cfg_i.area, 8'b0};
  assign step_ge = rem_q >= dsh_q;

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      BK_IDLE: begin
        if (!fifo_empty_i) begin
          state_d = sat ? BK_WRITE : BK_DIV;
        end
      end
      BK_DIV: begin
        if (cnt_q == 3'd0) begin
          state_d = BK_WRITE;
        end
      end
      BK_WRITE: begin
        if (!out_valid_q || pop) begin
          state_d = BK_IDLE;
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // Outputs of the sequencer.
  always_comb begin
    fifo_pop_o = 1'b0;
    out_load   = 1'b0;
    case (state_q)
      BK_IDLE:  fifo_pop_o = !fifo_empty_i;
      BK_WRITE: out_load   = !out_valid_q || pop;
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= BK_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Restoring divider, one quotient bit per cycle.
  always_ff @(posedge clk_i) begin
    case (state_q)
      BK_IDLE: begin
        rem_q <= fifo_data_i.sum;
        dsh_q <= {cfg_i.area, 7'b0};
        quo_q <= sat ? 8'hFF : 8'h00;
        cnt_q <= 3'd7;
        eor_q <= fifo_data_i.eor;
      end
      BK_DIV: begin
        if (step_ge) begin
          rem_q <= rem_q - dsh_q;
        end
        dsh_q <= {1'b0, dsh_q[SUM_W-1:1]};
        quo_q <= {quo_q[6:0], step_ge};
        cnt_q <= cnt_q - 3'd1;
      end
      default: ;
    endcase
  end

  // Optional inversion and bucket.
  assign value = cfg_i.invert ? 8'd255 - quo_q : quo_q;

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (pop) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      level_q   <= value[7:5];
      glyph_q   <= glyph_of(value[7:5]);
      out_eor_q <= eor_q;
    end
  end

  assign empty        = !out_valid_q;
  assign glyph_o      = glyph_q;
  assign level_o      = level_q;
  assign end_of_row_o = out_eor_q;

endmodule

@@ rtl/palette_block_average_to_glyph.sv @@
// Top level of the palette block-average glyph block.
//
// Input channel (push/full): an item is either a palette load, which stores
// the grey level of one palette entry, or a pixel given as a palette index
// in raster order. Pixels are taken at one per cycle while full is low; each
// pixel in a full block adds its grey level into its block column's running sum.
// Result channel (empty/pop): one item per full block, carrying the glyph,
// its brightness level and an end-of-row flag on the last block of a band.
// A finished block sum passes from the pixel stage through the queue to the
// back part, which divides it unless the average saturates and then loads the
// output register. The divider produces one quotient bit per cycle; blocks ten
// or more pixels wide keep the pixel stream at full rate, a four-entry queue
// absorbs bursts, and full rises when it could overflow.
// A configuration write recomputes the block counts with a serial divider;
// full stays high after the last write until the counts are settled.
// Reset restores the register defaults and clears all position counters.
// When the receiver stalls, results wait in the output register and the
// queue, after which full holds off further pixels; nothing is dropped.
module palette_block_average_to_glyph
  import pbag_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_AW-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               push,
  output logic               full,
  input  logic               action_i,
  input  logic [7:0]         color_index_i,
  input  logic [7:0]         blue_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         red_i,
  input  logic               frame_start_i,
  output logic               empty,
  input  logic               pop,
  output logic [GLYPH_W-1:0] glyph_o,
  output logic [LEVEL_W-1:0] level_o,
  output logic               end_of_row_o
);

  cfg_t               cfg;
  logic               fifo_push, fifo_pop, fifo_empty;
  blk_entry_t         fifo_wdata, fifo_rdata;
  logic [FIFO_CW-1:0] fifo_count;

  // Registers and derived counts.
  pbag_setup u_setup (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  // Loads, positions and accumulation.
  pbag_front u_front (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .color_index_i (color_index_i),
    .blue_i        (blue_i),
    .green_i       (green_i),
    .red_i         (red_i),
    .frame_start_i (frame_start_i),
    .cfg_i         (cfg),
    .fifo_count_i  (fifo_count),
    .fifo_push_o   (fifo_push),
    .fifo_data_o   (fifo_wdata)
  );

  // Completed block sums.
  pbag_fifo u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (fifo_push),
    .data_i  (fifo_wdata),
    .pop_i   (fifo_pop),
    .data_o  (fifo_rdata),
    .empty_o (fifo_empty),
    .count_o (fifo_count)
  );

  // Division and glyph output.
  pbag_back u_back (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .fifo_data_i  (fifo_rdata),
    .fifo_empty_i (fifo_empty),
    .fifo_pop_o   (fifo_pop),
    .cfg_i        (cfg),
    .pop          (pop),
    .empty        (empty),
    .glyph_o      (glyph_o),
    .level_o      (level_o),
    .end_of_row_o (end_of_row_o)
  );

endmodule

@@ tb/pbag_checker.sv @@
// Checker for the palette block-average glyph block: predicts each glyph and compares it.
`timescale 1ns / 1ps
module pbag_checker
  import pbag_pkg::*;
#(
  parameter logic LOAD_ACTION = 1'b0
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [CFG_AW-1:0]  cfg_index_i,
  input  logic [CFG_W-1:0]   cfg_data_i,
  input  logic               push_i,
  input  logic               full_i,
  input  logic               action_i,
  input  logic [7:0]         color_index_i,
  input  logic [7:0]         blue_i,
  input  logic [7:0]         green_i,
  input  logic [7:0]         red_i,
  input  logic               frame_start_i,
  input  logic               empty_i,
  input  logic               pop_i,
  input  logic [GLYPH_W-1:0] glyph_i,
  input  logic [LEVEL_W-1:0] level_i,
  input  logic               end_of_row_i,
  output int                 fail_count_o,
  output int                 pending_o
);

  localparam int REPORT_LIMIT = 10;

  // One finished block as it should leave the block.
  typedef struct packed {
    logic [GLYPH_W-1:0] glyph;
    logic [LEVEL_W-1:0] level;
    logic               eor;
  } glyph_res_t;

  // Register copies as last written.
  logic [IW_W-1:0] img_width;
  logic [BW_W-1:0] blk_width;
  logic [BH_W-1:0] blk_height;
  logic            invert;

  // Grey per palette entry and running sums per block column.
  logic [GREY_W-1:0] grey_table [PALETTE_ENTRIES];
  logic [SUM_W-1:0]  col_sums [MAX_BLOCK_COLUMNS];

  // Raster position inside the current band.
  logic [CP_W-1:0]  col_pos;
  logic [CIB_W-1:0] col_in_blk;
  logic [COL_W-1:0] blk_col;
  logic [RIB_W-1:0] row_in_band;

  glyph_res_t due_glyphs [$];
  int         mismatches = 0;

  initial begin
    fail_count_o = 0;
    pending_o    = 0;
  end

  // Glyph for a brightness value, darkest first.
  function automatic logic [GLYPH_W-1:0] glyph_for(input int unsigned v);
    if (v < 32) return CH_SPACE;
    if (v < 64) return CH_DOT;
    if (v < 96) return CH_DASH;
    if (v < 128) return CH_PLUS;
    if (v < 160) return CH_STAR;
    if (v < 192) return CH_AMP;
    if (v < 224) return CH_PCT;
    return CH_HASH;
  endfunction

  // Accumulate one pixel and queue a glyph when it closes a full block.
  task automatic accumulate_pixel(input logic [7:0] idx, input logic restart);
    int unsigned iw, bw, bh, ncols, avg, v, next_col;
    logic [SUM_W-1:0] total;
    glyph_res_t res;
    if (restart) begin
      col_pos     = '0;
      col_in_blk  = '0;
      blk_col     = '0;
      row_in_band = '0;
    end
    // Out-of-range registers saturate; zero counts as one.
    iw = (img_width == 0) ? 1 : ((img_width > MAX_IMAGE_WIDTH) ? MAX_IMAGE_WIDTH : img_width);
    bw = (blk_width == 0) ? 1 : ((blk_width > BW_MAX) ? BW_MAX : blk_width);
    bh = (blk_height == 0) ? 1 : ((blk_height > BH_MAX) ? BH_MAX : blk_height);
    ncols = iw / bw;
    if (ncols > MAX_BLOCK_COLUMNS) ncols = MAX_BLOCK_COLUMNS;

    if (ncols > 0 && col_pos < ncols * bw && blk_col < ncols) begin
      if (row_in_band == 0 && col_in_blk == 0) total = grey_table[idx];
      else total = col_sums[blk_col] + grey_table[idx];
      col_sums[blk_col] = total;
      if (col_in_blk >= bw - 1 && row_in_band >= bh - 1) begin
        avg = total / (bw * bh);
        if (avg > 255) avg = 255;
        v = invert ? 255 - avg : avg;
        res.level = v[7:5];
        res.glyph = glyph_for(v);
        res.eor   = (blk_col == ncols - 1);
        due_glyphs.push_back(res);
      end
    end

    // Step the raster position, wrapping at the row and band edges.
    if (col_pos >= iw - 1) begin
      col_pos    = '0;
      col_in_blk = '0;
      blk_col    = '0;
      if (row_in_band >= bh - 1) row_in_band = '0;
      else row_in_band = row_in_band + 1'b1;
    end else begin
      col_pos = col_pos + 1'b1;
      if (col_in_blk >= bw - 1) begin
        col_in_blk = '0;
        next_col = (blk_col + 1 < ncols) ? blk_col + 1 : ncols;
        if (next_col > MAX_BLOCK_COLUMNS - 1) next_col = MAX_BLOCK_COLUMNS - 1;
        blk_col = next_col[COL_W-1:0];
      end else begin
        col_in_blk = col_in_blk + 1'b1;
      end
    end
  endtask

  // Watch all three channels at each edge.
  always @(posedge clk_i or negedge rst_ni) begin : watch
    glyph_res_t  want;
    int unsigned weighted;
    if (!rst_ni) begin
      img_width   = IW_RESET;
      blk_width   = BW_RESET;
      blk_height  = BH_RESET;
      invert      = 1'b0;
      col_pos     = '0;
      col_in_blk  = '0;
      blk_col     = '0;
      row_in_band = '0;
      due_glyphs.delete();
    end else begin
      // Results leave before anything accepted at this edge can produce one.
      if (pop_i && !empty_i) begin
        if (due_glyphs.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_LIMIT)
            $display("%0t: unexpected glyph %h level %0d end_of_row %0b", $realtime,
                     glyph_i, level_i, end_of_row_i);
        end else begin
          want = due_glyphs.pop_front();
          if (glyph_i !== want.glyph || level_i !== want.level ||
              end_of_row_i !== want.eor)
          begin
            mismatches++;
            if (mismatches <= REPORT_LIMIT)
              $display("%0t: glyph mismatch: expected %h/%0d/%0b, got %h/%0d/%0b",
                       $realtime, want.glyph, want.level, want.eor,
                       glyph_i, level_i, end_of_row_i);
          end
        end
      end

      if (cfg_we_i) begin
        case (cfg_index_i)
          REG_IMAGE_WIDTH:  img_width  = cfg_data_i[IW_W-1:0];
          REG_BLOCK_WIDTH:  blk_width  = cfg_data_i[BW_W-1:0];
          REG_BLOCK_HEIGHT: blk_height = cfg_data_i[BH_W-1:0];
          default:          invert     = cfg_data_i[0];
        endcase
      end

      if (push_i && !full_i) begin
        if (action_i == LOAD_ACTION) begin
          weighted = 28 * blue_i + 151 * green_i + 77 * red_i;
          grey_table[color_index_i] = weighted[GREY_W+7:8];
        end else begin
          accumulate_pixel(color_index_i, frame_start_i);
        end
      end
    end
    fail_count_o <= mismatches;
    pending_o    <= due_glyphs.size();
  end

endmodule

@@ tb/tb_top.sv @@
// Testbench top for the palette block-average glyph block: stimulus, idling and verdict.
`timescale 1ns / 1ps
module tb_top;
  import pbag_pkg::*;

  localparam logic ACT_LOAD      = 1'b0;
  localparam logic ACT_PIXEL     = 1'b1;
  localparam int   ITEM_TARGET   = 1100;
  localparam int   SETTLE_CYCLES = 40;
  localparam int   QUIET_LIMIT   = 2000;

  logic               clk_i         = 1'b0;
  logic               rst_ni        = 1'b0;
  logic               cfg_we_i      = 1'b0;
  logic [CFG_AW-1:0]  cfg_index_i   = '0;
  logic [CFG_W-1:0]   cfg_data_i    = '0;
  logic               push          = 1'b0;
  logic               full;
  logic               action_i      = 1'b0;
  logic [7:0]         color_index_i = '0;
  logic [7:0]         blue_i        = '0;
  logic [7:0]         green_i       = '0;
  logic [7:0]         red_i         = '0;
  logic               frame_start_i = 1'b0;
  logic               empty;
  logic               pop           = 1'b0;
  logic [GLYPH_W-1:0] glyph_o;
  logic [LEVEL_W-1:0] level_o;
  logic               end_of_row_o;

  bit         calm         = 1'b1;
  int         pop_hold     = 0;
  int         quiet_cycles = 0;
  int         sent_items   = 0;
  int         fail_count;
  int         pending;
  logic [7:0] loaded_idx [$];
  bit         is_loaded [PALETTE_ENTRIES];

  palette_block_average_to_glyph uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push          (push),
    .full          (full),
    .action_i      (action_i),
    .color_index_i (color_index_i),
    .blue_i        (blue_i),
    .green_i       (green_i),
    .red_i         (red_i),
    .frame_start_i (frame_start_i),
    .empty         (empty),
    .pop           (pop),
    .glyph_o       (glyph_o),
    .level_o       (level_o),
    .end_of_row_o  (end_of_row_o)
  );

  pbag_checker #(
    .LOAD_ACTION (ACT_LOAD)
  ) chk (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .push_i        (push),
    .full_i        (full),
    .action_i      (action_i),
    .color_index_i (color_index_i),
    .blue_i        (blue_i),
    .green_i       (green_i),
    .red_i         (red_i),
    .frame_start_i (frame_start_i),
    .empty_i       (empty),
    .pop_i         (pop),
    .glyph_i       (glyph_o),
    .level_i       (level_o),
    .end_of_row_i  (end_of_row_o),
    .fail_count_o  (fail_count),
    .pending_o     (pending)
  );

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Random idle length: mostly none, some short, a few long.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm || r < 65) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // The receiver takes results with random stalls.
  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pop      <= 1'b0;
      pop_hold <= 0;
    end else if (pop_hold != 0) begin
      pop      <= 1'b0;
      pop_hold <= pop_hold - 1;
    end else begin
      pop      <= 1'b1;
      pop_hold <= idle_len();
    end
  end

  // End the run when nothing moves for too long.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((push && !full) || (pop && !empty) || cfg_we_i) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles >= QUIET_LIMIT) begin
        $display("Verification failed");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Offer one item and return at the edge that accepts it.
  task automatic send_item(input logic act, input logic [7:0] idx,
                           input logic [7:0] b, input logic [7:0] g, input logic [7:0] r,
                           input logic restart);
    int gap;
    gap = idle_len();
    if (gap != 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    push          <= 1'b1;
    action_i      <= act;
    color_index_i <= idx;
    blue_i        <= b;
    green_i       <= g;
    red_i         <= r;
    frame_start_i <= restart;
    if (act == ACT_LOAD && !is_loaded[idx]) begin
      is_loaded[idx] = 1'b1;
      loaded_idx.push_back(idx);
    end
    sent_items++;
    do @(posedge clk_i); while (full);
  endtask

  // Pixels only ever use palette entries that were loaded.
  task automatic send_pixel(input logic restart);
    logic [7:0] idx;
    idx = loaded_idx[$urandom_range(0, loaded_idx.size() - 1)];
    send_item(ACT_PIXEL, idx, $urandom, $urandom, $urandom, restart);
  endtask

  // A stretch of pixels with palette loads mixed in.
  task automatic run_phase(input int n, input bit restart_first, input bit restarts);
    bit restart;
    for (int i = 0; i < n; i++) begin
      if (i != 0 && $urandom_range(0, 7) == 0) begin
        send_item(ACT_LOAD, $urandom, $urandom, $urandom, $urandom, $urandom_range(0, 1));
      end else begin
        restart = (i == 0) ? restart_first : (restarts && $urandom_range(0, 39) == 0);
        send_pixel(restart);
      end
    end
    push <= 1'b0;
  endtask

  // Wait until every expected glyph is out and the back end has gone quiet.
  // The pending count is registered, so it lags the accepting edge.
  task automatic settle();
    @(posedge clk_i);
    while (pending != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [CFG_W-1:0] val);
    cfg_we_i    <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    @(posedge clk_i);
  endtask

  // Write the registers selected by mask, one per cycle.
  task automatic program_regs(input logic [CFG_W-1:0] iw, input logic [CFG_W-1:0] bw,
                              input logic [CFG_W-1:0] bh, input logic inv,
                              input logic [3:0] mask);
    if (mask[REG_IMAGE_WIDTH]) write_reg(REG_IMAGE_WIDTH, iw);
    if (mask[REG_BLOCK_WIDTH]) write_reg(REG_BLOCK_WIDTH, bw);
    if (mask[REG_BLOCK_HEIGHT]) write_reg(REG_BLOCK_HEIGHT, bh);
    if (mask[REG_INVERT_MODE]) write_reg(REG_INVERT_MODE, {{(CFG_W-1){1'b0}}, inv});
    cfg_we_i <= 1'b0;
  endtask

  initial begin : stimulus
    logic [CFG_W-1:0] iw, bw, bh;
    int r;
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    repeat (2) @(posedge clk_i);

    // Zero sizes saturate to one, so every pixel is a block of its own.
    program_regs('0, '0, '0, 1'b0, 4'hF);
    // Palette extremes and one color per glyph bucket; a frame start on a load is ignored.
    send_item(ACT_LOAD, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_item(ACT_LOAD, 8'd1, 8'd255, 8'd0, 8'd0, 1'b0);
    send_item(ACT_LOAD, 8'd2, 8'd0, 8'd255, 8'd0, 1'b0);
    send_item(ACT_LOAD, 8'd3, 8'd0, 8'd0, 8'd255, 1'b0);
    send_item(ACT_LOAD, 8'd4, 8'd0, 8'd60, 8'd0, 1'b1);
    send_item(ACT_LOAD, 8'd5, 8'd0, 8'd180, 8'd0, 1'b0);
    send_item(ACT_LOAD, 8'd6, 8'd255, 8'd255, 8'd0, 1'b0);
    send_item(ACT_LOAD, 8'd7, 8'd0, 8'd255, 8'd200, 1'b0);
    send_item(ACT_LOAD, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    for (int i = 0; i < 8; i++) send_item(ACT_PIXEL, i, 8'd0, 8'd0, 8'd0, i == 0);
    send_item(ACT_PIXEL, 8'd255, 8'd255, 8'd255, 8'd255, 1'b0);
    push <= 1'b0;
    settle();
    program_regs('0, '0, '0, 1'b1, 4'b1000);
    send_item(ACT_PIXEL, 8'd255, 8'd0, 8'd0, 8'd0, 1'b0);
    send_item(ACT_PIXEL, 8'd0, 8'd0, 8'd0, 8'd0, 1'b0);
    send_item(ACT_PIXEL, 8'd6, 8'd0, 8'd0, 8'd0, 1'b0);
    push <= 1'b0;
    settle();

    // More block columns than storage: only the first 128 of each row count.
    // One clean row here also fills every column sum before any mid-frame change.
    calm <= 1'b0;
    program_regs(13'd200, 13'd1, 13'd1, $urandom_range(0, 1), 4'hF);
    run_phase(240, 1'b1, 1'b0);
    settle();

    // Tallest block in a one-pixel-wide image.
    program_regs(13'd1, 13'd1, 13'd128, $urandom_range(0, 1), 4'hF);
    run_phase(300, 1'b1, 1'b1);
    settle();

    // Oversized width and block width saturate; zero height counts as one.
    program_regs(13'h1FFF, 13'd127, 13'd0, $urandom_range(0, 1), 4'hF);
    run_phase(300, 1'b1, 1'b1);
    settle();

    // Random settings, mostly small blocks, sometimes changed mid-frame.
    while (sent_items < ITEM_TARGET) begin
      calm <= ($urandom_range(0, 4) == 0);
      r = $urandom_range(0, 19);
      if (r == 0) iw = '0;
      else if (r == 1) iw = $urandom_range(4096, 8191);
      else if (r < 4) iw = $urandom_range(25, 300);
      else iw = $urandom_range(1, 24);
      r = $urandom_range(0, 19);
      if (r == 0) bw = '0;
      else if (r == 1) bw = $urandom_range(64, 127);
      else bw = $urandom_range(1, 6);
      r = $urandom_range(0, 19);
      if (r == 0) bh = '0;
      else if (r == 1) bh = $urandom_range(128, 255);
      else bh = $urandom_range(1, 4);
      program_regs(iw, bw, bh, $urandom_range(0, 1), $urandom_range(1, 15));
      run_phase($urandom_range(30, 120), $urandom_range(0, 3) != 0, 1'b1);
      settle();
    end

    if (fail_count == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
